FILE: rtl/core/sbc_pkg.sv
// shared types, constants and helpers for the segment box clearance test
package sbc_pkg;

  localparam int WORDS_PER_REGION = 14;
  localparam int XW   = 33;   // start or end minus center
  localparam int AXW  = 18;   // saturated axis component
  localparam int PW   = 52;   // projection
  localparam int NUMW = 54;   // clip numerator
  localparam int DENW = 53;   // clip denominator
  localparam int ACCW = 110;  // cross product accumulator
  localparam int HW   = 33;   // slab half extent

  localparam logic [2:0] KIND_QUERY  = 3'd0;
  localparam logic [2:0] KIND_CENTER = 3'd1;
  localparam logic [2:0] KIND_HALF   = 3'd5;

  localparam logic [1:0] REG_REGIONS = 2'd0;
  localparam logic [1:0] REG_PADDING = 2'd1;
  localparam logic [1:0] REG_MIN_VERT = 2'd2;

  localparam logic [15:0] PADDING_RESET  = 16'd1280;
  localparam logic [23:0] MIN_VERT_RESET = 24'd25600;

  typedef logic signed [XW-1:0] diff_t;
  typedef diff_t diff3_t [3];
  typedef logic [31:0] word3_t [3];

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH,
    ST_PREP,
    ST_PROJ,
    ST_SLAB,
    ST_CMP_LO,
    ST_CMP_HI,
    ST_CMP_IV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic done;
    logic lt;
    logic gt;
  } rcmp_res_t;

  function automatic logic signed [AXW-1:0] sat_axis(input logic [31:0] w);
    logic signed [31:0] v;
    v = $signed(w);
    if (v > 32'sd65536) begin
      return 18'sd65536;
    end else if (v < -32'sd65536) begin
      return -18'sd65536;
    end
    return v[AXW-1:0];
  endfunction

  function automatic logic [30:0] half_size(input logic [31:0] w);
    return w[31] ? 31'd0 : w[30:0];
  endfunction

endpackage

FILE: rtl/core/sbc_mac.sv
// bit-serial projection unit: start and end differences dotted with one axis
module sbc_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  sbc_pkg::diff3_t              x0,
  input  sbc_pkg::diff3_t              x1,
  input  sbc_pkg::word3_t              ax,
  output logic                         done,
  output logic signed [sbc_pkg::PW-1:0] s,
  output logic signed [sbc_pkg::PW-1:0] e
);

  logic                             run_r;
  logic                             done_r;
  logic [1:0]                       comp_r;
  logic [4:0]                       bit_r;
  sbc_pkg::diff3_t                  x0_r;
  sbc_pkg::diff3_t                  x1_r;
  logic signed [sbc_pkg::AXW-1:0]   ax_r [3];
  logic signed [sbc_pkg::PW-1:0]    m0_r;
  logic signed [sbc_pkg::PW-1:0]    m1_r;
  logic [sbc_pkg::AXW-1:0]          a_r;
  logic signed [sbc_pkg::PW-1:0]    acc0_r;
  logic signed [sbc_pkg::PW-1:0]    acc1_r;
  logic signed [sbc_pkg::PW-1:0]    acc0_nxt;
  logic signed [sbc_pkg::PW-1:0]    acc1_nxt;
  logic                             last_bit;

  assign last_bit = (bit_r == 5'(sbc_pkg::AXW - 1));

  // sign bit of the axis carries negative weight
  always_comb begin
    acc0_nxt = acc0_r;
    acc1_nxt = acc1_r;
    if (a_r[0]) begin
      if (last_bit) begin
        acc0_nxt = acc0_r - m0_r;
        acc1_nxt = acc1_r - m1_r;
      end else begin
        acc0_nxt = acc0_r + m0_r;
        acc1_nxt = acc1_r + m1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      comp_r <= 2'd0;
      bit_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        comp_r <= 2'd0;
        bit_r  <= 5'd0;
      end else if (run_r) begin
        if (last_bit) begin
          bit_r <= 5'd0;
          if (comp_r == 2'd2) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end else begin
          bit_r <= bit_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x0_r   <= x0;
      x1_r   <= x1;
      for (int k = 0; k < 3; k++) begin
        ax_r[k] <= sbc_pkg::sat_axis(ax[k]);
      end
      m0_r   <= sbc_pkg::PW'(x0[0]);
      m1_r   <= sbc_pkg::PW'(x1[0]);
      a_r    <= sbc_pkg::sat_axis(ax[0]);
      acc0_r <= '0;
      acc1_r <= '0;
    end else if (run_r) begin
      acc0_r <= acc0_nxt;
      acc1_r <= acc1_nxt;
      if (last_bit) begin
        if (comp_r != 2'd2) begin
          m0_r <= sbc_pkg::PW'(x0_r[comp_r + 2'd1]);
          m1_r <= sbc_pkg::PW'(x1_r[comp_r + 2'd1]);
          a_r  <= ax_r[comp_r + 2'd1];
        end
      end else begin
        m0_r <= m0_r <<< 1;
        m1_r <= m1_r <<< 1;
        a_r  <= a_r >> 1;
      end
    end
  end

  assign done = done_r;
  assign s    = acc0_r;
  assign e    = acc1_r;

endmodule

FILE: rtl/core/sbc_rcmp.sv
// bit-serial rational compare: sign of a*d - c*b, one denominator bit per cycle
module sbc_rcmp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [sbc_pkg::NUMW-1:0]  a,
  input  logic [sbc_pkg::DENW-1:0]         b,
  input  logic signed [sbc_pkg::NUMW-1:0]  c,
  input  logic [sbc_pkg::DENW-1:0]         d,
  output sbc_pkg::rcmp_res_t               res
);

  logic                              run_r;
  logic                              done_r;
  logic [5:0]                        cnt_r;
  logic signed [sbc_pkg::NUMW-1:0]   a_r;
  logic signed [sbc_pkg::NUMW-1:0]   c_r;
  logic [sbc_pkg::DENW-1:0]          b_r;
  logic [sbc_pkg::DENW-1:0]          d_r;
  logic signed [sbc_pkg::ACCW-1:0]   acc_r;
  logic signed [sbc_pkg::ACCW-1:0]   term;
  logic signed [sbc_pkg::ACCW-1:0]   acc_nxt;

  // msb first: acc = 2*acc + d_bit*a - b_bit*c
  always_comb begin
    term = (d_r[sbc_pkg::DENW-1] ? sbc_pkg::ACCW'(a_r) : '0)
         - (b_r[sbc_pkg::DENW-1] ? sbc_pkg::ACCW'(c_r) : '0);
    acc_nxt = (acc_r <<< 1) + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 6'd0;
      end else if (run_r) begin
        if (cnt_r == 6'(sbc_pkg::DENW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      c_r   <= c;
      b_r   <= b;
      d_r   <= d;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      b_r   <= b_r << 1;
      d_r   <= d_r << 1;
    end
  end

  assign res.done = done_r;
  assign res.lt   = acc_r[sbc_pkg::ACCW-1];
  assign res.gt   = !acc_r[sbc_pkg::ACCW-1] && (acc_r != '0);

endmodule

FILE: rtl/core/segment_box_clearance_test.sv
// top level: box table, configuration registers and query sequencer
// a load writes 3 words (2 for half sizes), busy high meanwhile
// a query searches the boxes in order and stops at the first hit
// per box: 14 table reads and a setup step, then per slab a run of the serial
// projection unit, a step to form the bounds and up to 3 runs of the serial rational compare unit
// results cannot be stalled; synchronous active-low reset clears control and configuration registers
module segment_box_clearance_test #(
  parameter int MAX_REGIONS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [5:0]  in_region_index,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_first_z,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_end_z,
  input  logic [23:0] in_span_width,
  input  logic [23:0] in_span_height,
  output logic        out_valid,
  output logic        out_touches,
  output logic [5:0]  out_hit_region,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_REGIONS * sbc_pkg::WORDS_PER_REGION;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(MAX_REGIONS + 1);

  sbc_pkg::state_t state_r, state_nxt;
  logic            go_r;

  logic [6:0]  cfg_regions_r;
  logic [15:0] cfg_padding_r;
  logic [23:0] cfg_min_vert_r;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [31:0] wr_data;
  logic        mem_we;

  logic signed [31:0] p0_r [3];
  logic signed [31:0] p1_r [3];
  logic [23:0] wid_r;
  logic [23:0] hgt_r;
  logic [2:0]  ld_kind_r;
  logic [5:0]  ld_idx_r;
  logic [31:0] ld_w_r [3];
  logic [1:0]  ld_cnt_r;
  logic [BW-1:0] box_r;
  logic [BW-1:0] lim_r;
  logic [3:0]  wd_r;
  logic [31:0] bank_r [sbc_pkg::WORDS_PER_REGION];
  sbc_pkg::diff3_t d0_r;
  sbc_pkg::diff3_t d1_r;
  logic [sbc_pkg::HW-1:0] h_r [3];
  logic [1:0]  slab_r;
  logic signed [sbc_pkg::NUMW-1:0] en_r;
  logic signed [sbc_pkg::NUMW-1:0] lv_r;
  logic [sbc_pkg::DENW-1:0] dn_r;
  logic signed [sbc_pkg::NUMW-1:0] lo_num_r;
  logic signed [sbc_pkg::NUMW-1:0] hi_num_r;
  logic [sbc_pkg::DENW-1:0] lo_den_r;
  logic [sbc_pkg::DENW-1:0] hi_den_r;
  logic        touch_r;
  logic [5:0]  hit_r;

  logic        cfg_we;
  logic        accept;
  logic        is_query;
  logic        load_ok;
  logic [BW-1:0] lim_new;
  logic        last_box;
  logic        ld_last;

  sbc_pkg::word3_t ax_sel;
  logic        mac_start;
  logic        mac_done;
  logic signed [sbc_pkg::PW-1:0] mac_s;
  logic signed [sbc_pkg::PW-1:0] mac_e;

  logic        cmp_start;
  logic signed [sbc_pkg::NUMW-1:0] cmp_a;
  logic signed [sbc_pkg::NUMW-1:0] cmp_c;
  logic [sbc_pkg::DENW-1:0] cmp_b;
  logic [sbc_pkg::DENW-1:0] cmp_d;
  sbc_pkg::rcmp_res_t cmp_res;

  logic signed [49:0] hs;
  logic signed [52:0] dd;
  logic signed [52:0] abs_s;
  logic signed [52:0] sn;
  logic        dd_zero;
  logic        zpass;
  logic        slab_ok;
  logic        slab_bad;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_regions_r  <= 7'd0;
      cfg_padding_r  <= sbc_pkg::PADDING_RESET;
      cfg_min_vert_r <= sbc_pkg::MIN_VERT_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        sbc_pkg::REG_REGIONS:  cfg_regions_r  <= pwdata[6:0];
        sbc_pkg::REG_PADDING:  cfg_padding_r  <= pwdata[15:0];
        sbc_pkg::REG_MIN_VERT: cfg_min_vert_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sbc_pkg::REG_REGIONS:  prdata = {25'd0, cfg_regions_r};
      sbc_pkg::REG_PADDING:  prdata = {16'd0, cfg_padding_r};
      sbc_pkg::REG_MIN_VERT: prdata = {8'd0, cfg_min_vert_r};
      default:               prdata = 32'd0;
    endcase
  end

  // transaction decode
  assign accept   = start && (state_r == sbc_pkg::ST_IDLE);
  assign is_query = (in_kind == sbc_pkg::KIND_QUERY);
  assign load_ok  = (in_kind >= sbc_pkg::KIND_CENTER) && (in_kind <= sbc_pkg::KIND_HALF)
                 && (32'(in_region_index) < 32'(MAX_REGIONS));
  assign lim_new  = (32'(cfg_regions_r) > 32'(MAX_REGIONS)) ? BW'(MAX_REGIONS)
                                                           : BW'(cfg_regions_r);
  assign last_box = ((BW + 1)'(box_r) + (BW + 1)'(1)) == (BW + 1)'(lim_r);
  assign ld_last  = (ld_kind_r == sbc_pkg::KIND_HALF) ? (ld_cnt_r == 2'd1)
                                                      : (ld_cnt_r == 2'd2);

  // box table
  always_comb begin
    wr_addr = AW'(ld_idx_r) * AW'(sbc_pkg::WORDS_PER_REGION)
            + AW'(3 * (int'(ld_kind_r) - 1)) + AW'(ld_cnt_r);
    wr_data = ld_w_r[ld_cnt_r];
    rd_addr = AW'(box_r) * AW'(sbc_pkg::WORDS_PER_REGION)
            + ((wd_r < 4'(sbc_pkg::WORDS_PER_REGION)) ? AW'(wd_r) : AW'(0));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // slab arithmetic
  always_comb begin
    hs      = $signed({1'b0, h_r[slab_r], 16'd0});
    dd      = 53'(mac_e) - 53'(mac_s);
    dd_zero = (dd == '0);
    abs_s   = mac_s[sbc_pkg::PW-1] ? -53'(mac_s) : 53'(mac_s);
    zpass   = abs_s <= 53'(hs);
    sn      = dd[52] ? -53'(mac_s) : 53'(mac_s);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax_sel[k] = bank_r[4'(3 + 3 * int'(slab_r) + k)];
    end
  end

  always_comb begin
    case (state_r)
      sbc_pkg::ST_CMP_LO: begin
        cmp_a = en_r;     cmp_b = dn_r;     cmp_c = lo_num_r; cmp_d = lo_den_r;
      end
      sbc_pkg::ST_CMP_HI: begin
        cmp_a = lv_r;     cmp_b = dn_r;     cmp_c = hi_num_r; cmp_d = hi_den_r;
      end
      default: begin
        cmp_a = lo_num_r; cmp_b = lo_den_r; cmp_c = hi_num_r; cmp_d = hi_den_r;
      end
    endcase
  end

  assign slab_ok  = ((state_r == sbc_pkg::ST_SLAB) && dd_zero && zpass)
                 || ((state_r == sbc_pkg::ST_CMP_IV) && cmp_res.done && !cmp_res.gt);
  assign slab_bad = ((state_r == sbc_pkg::ST_SLAB) && dd_zero && !zpass)
                 || ((state_r == sbc_pkg::ST_CMP_IV) && cmp_res.done && cmp_res.gt);

  sbc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .x0    (d0_r),
    .x1    (d1_r),
    .ax    (ax_sel),
    .done  (mac_done),
    .s     (mac_s),
    .e     (mac_e)
  );

  sbc_rcmp u_rcmp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmp_start),
    .a     (cmp_a),
    .b     (cmp_b),
    .c     (cmp_c),
    .d     (cmp_d),
    .res   (cmp_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbc_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_query) begin
            state_nxt = (lim_new == '0) ? sbc_pkg::ST_DONE : sbc_pkg::ST_FETCH;
          end else if (load_ok) begin
            state_nxt = sbc_pkg::ST_LOAD;
          end
        end
      end
      sbc_pkg::ST_LOAD: begin
        if (ld_last) state_nxt = sbc_pkg::ST_IDLE;
      end
      sbc_pkg::ST_FETCH: begin
        if (wd_r == 4'(sbc_pkg::WORDS_PER_REGION)) state_nxt = sbc_pkg::ST_PREP;
      end
      sbc_pkg::ST_PREP: state_nxt = sbc_pkg::ST_PROJ;
      sbc_pkg::ST_PROJ: begin
        if (mac_done) state_nxt = sbc_pkg::ST_SLAB;
      end
      sbc_pkg::ST_SLAB: begin
        if (!dd_zero) state_nxt = sbc_pkg::ST_CMP_LO;
      end
      sbc_pkg::ST_CMP_LO: begin
        if (cmp_res.done) state_nxt = sbc_pkg::ST_CMP_HI;
      end
      sbc_pkg::ST_CMP_HI: begin
        if (cmp_res.done) state_nxt = sbc_pkg::ST_CMP_IV;
      end
      sbc_pkg::ST_CMP_IV: ;
      sbc_pkg::ST_DONE: state_nxt = sbc_pkg::ST_IDLE;
      default: state_nxt = sbc_pkg::ST_IDLE;
    endcase
    if (slab_ok) begin
      state_nxt = (slab_r == 2'd2) ? sbc_pkg::ST_DONE : sbc_pkg::ST_PROJ;
    end else if (slab_bad) begin
      state_nxt = last_box ? sbc_pkg::ST_DONE : sbc_pkg::ST_FETCH;
    end
  end

  // outputs
  always_comb begin
    busy      = (state_r != sbc_pkg::ST_IDLE);
    out_valid = (state_r == sbc_pkg::ST_DONE);
    mem_we    = (state_r == sbc_pkg::ST_LOAD);
    mac_start = go_r && (state_r == sbc_pkg::ST_PROJ);
    cmp_start = go_r && ((state_r == sbc_pkg::ST_CMP_LO) || (state_r == sbc_pkg::ST_CMP_HI)
                      || (state_r == sbc_pkg::ST_CMP_IV));
  end

  assign out_touches    = touch_r;
  assign out_hit_region = hit_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sbc_pkg::ST_IDLE;
      go_r     <= 1'b0;
      ld_cnt_r <= 2'd0;
      box_r    <= '0;
      lim_r    <= '0;
      wd_r     <= 4'd0;
      slab_r   <= 2'd0;
      touch_r  <= 1'b0;
      hit_r    <= 6'd0;
    end else begin
      state_r <= state_nxt;
      go_r    <= (state_nxt != state_r);
      case (state_r)
        sbc_pkg::ST_IDLE: begin
          ld_cnt_r <= 2'd0;
          box_r    <= '0;
          wd_r     <= 4'd0;
          if (accept && is_query) begin
            lim_r   <= lim_new;
            touch_r <= 1'b0;
            hit_r   <= 6'd0;
          end
        end
        sbc_pkg::ST_LOAD:  ld_cnt_r <= ld_cnt_r + 2'd1;
        sbc_pkg::ST_FETCH: wd_r <= wd_r + 4'd1;
        sbc_pkg::ST_PREP:  slab_r <= 2'd0;
        default: ;
      endcase
      if (slab_ok) begin
        if (slab_r == 2'd2) begin
          touch_r <= 1'b1;
          hit_r   <= 6'(box_r);
        end else begin
          slab_r <= slab_r + 2'd1;
        end
      end else if (slab_bad && !last_box) begin
        box_r <= box_r + BW'(1);
        wd_r  <= 4'd0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      sbc_pkg::ST_IDLE: begin
        if (accept) begin
          p0_r[0]   <= in_first_x;
          p0_r[1]   <= in_first_y;
          p0_r[2]   <= in_first_z;
          p1_r[0]   <= in_end_x;
          p1_r[1]   <= in_end_y;
          p1_r[2]   <= in_end_z;
          wid_r     <= in_span_width;
          hgt_r     <= in_span_height;
          ld_kind_r <= in_kind;
          ld_idx_r  <= in_region_index;
          ld_w_r[0] <= in_first_x;
          ld_w_r[1] <= in_first_y;
          ld_w_r[2] <= in_first_z;
        end
      end
      sbc_pkg::ST_FETCH: begin
        if (wd_r != 4'd0) begin
          bank_r[wd_r - 4'd1] <= rd_data_r;
        end
      end
      sbc_pkg::ST_PREP: begin
        for (int k = 0; k < 3; k++) begin
          d0_r[k] <= sbc_pkg::XW'(p0_r[k]) - sbc_pkg::XW'($signed(bank_r[k]));
          d1_r[k] <= sbc_pkg::XW'(p1_r[k]) - sbc_pkg::XW'($signed(bank_r[k]));
        end
        h_r[0] <= sbc_pkg::HW'(sbc_pkg::half_size(bank_r[12])) + sbc_pkg::HW'(wid_r)
                + sbc_pkg::HW'(cfg_padding_r);
        h_r[1] <= sbc_pkg::HW'(sbc_pkg::half_size(bank_r[13]))
                + sbc_pkg::HW'(cfg_padding_r);
        if ((25'(hgt_r) + 25'(wid_r)) < 25'(cfg_min_vert_r)) begin
          h_r[2] <= sbc_pkg::HW'(cfg_min_vert_r);
        end else begin
          h_r[2] <= sbc_pkg::HW'(25'(hgt_r) + 25'(wid_r));
        end
        lo_num_r <= '0;
        lo_den_r <= sbc_pkg::DENW'(1);
        hi_num_r <= sbc_pkg::NUMW'(1);
        hi_den_r <= sbc_pkg::DENW'(1);
      end
      sbc_pkg::ST_SLAB: begin
        en_r <= -sbc_pkg::NUMW'(hs) - sbc_pkg::NUMW'(sn);
        lv_r <= sbc_pkg::NUMW'(hs) - sbc_pkg::NUMW'(sn);
        dn_r <= dd[52] ? sbc_pkg::DENW'(-dd) : sbc_pkg::DENW'(dd);
      end
      sbc_pkg::ST_CMP_LO: begin
        if (cmp_res.done && cmp_res.gt) begin
          lo_num_r <= en_r;
          lo_den_r <= dn_r;
        end
      end
      sbc_pkg::ST_CMP_HI: begin
        if (cmp_res.done && cmp_res.lt) begin
          hi_num_r <= lv_r;
          hi_den_r <= dn_r;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/sbc_checker.sv
// port-level checks for the segment box clearance test, bound to the top level
module sbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_kind,
  input logic       out_valid,
  input logic       out_touches,
  input logic [5:0] out_hit_region,
  input logic       pready
);

  // a query started while idle holds the block busy
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind == sbc_pkg::KIND_QUERY) |=> busy)
    else $error("query transaction not taken");

  // a result only ends a busy period
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result without a query in flight");

  // one result per query, never two in a row
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result repeated");

  // a miss reports box zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_touches |-> out_hit_region == 6'd0)
    else $error("miss with nonzero box");

  assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind segment_box_clearance_test sbc_checker u_sbc_checker (.*);
